### hw/rtl/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types and sizes for the register allocator with context stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rac_pkg;

	localparam int NARROW_REGS = 6;
	localparam int WIDE_REGS   = 4;
	localparam int STACK_DEPTH = 16;

	localparam int OP_W   = 3;
	localparam int IDX_W  = 3;
	localparam int ERR_W  = 3;
	localparam int MAP_W  = NARROW_REGS + WIDE_REGS;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef logic [NARROW_REGS-1:0] narrow_map_t;
	typedef logic [WIDE_REGS-1:0]   wide_map_t;

	typedef enum logic [OP_W-1:0] {
		OP_CLAIM       = 3'd0,
		OP_ALLOC       = 3'd1,
		OP_RELEASE     = 3'd2,
		OP_RELEASE_ALL = 3'd3,
		OP_PUSH        = 3'd4,
		OP_POP         = 3'd5
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK         = 3'd0,
		ERR_BUSY       = 3'd1,
		ERR_NONE_FREE  = 3'd2,
		ERR_STACK_FULL = 3'd3,
		ERR_RANGE      = 3'd4
	} err_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

### hw/rtl/rac_req_if.sv
// ----------------------------------------------------------------------------
// rac_req_if
// Request channel: operation, register class and register index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rac_req_if
	import rac_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic             wide_class;
	logic [IDX_W-1:0] reg_index;

	modport source (output valid, output operation, output wide_class, output reg_index,
		input ready);
	modport sink (input valid, input operation, input wide_class, input reg_index,
		output ready);
endinterface

### hw/rtl/rac_rsp_if.sv
// ----------------------------------------------------------------------------
// rac_rsp_if
// Response channel: granted index, error code and both busy maps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rac_rsp_if
	import rac_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] granted_index;
	logic [ERR_W-1:0] error_code;
	narrow_map_t      narrow_map;
	wide_map_t        wide_map;

	modport source (output valid, output granted_index, output error_code,
		output narrow_map, output wide_map, input ready);
	modport sink (input valid, input granted_index, input error_code,
		input narrow_map, input wide_map, output ready);
endinterface

### hw/rtl/register_allocator_with_context_stack.sv
// ----------------------------------------------------------------------------
// register_allocator_with_context_stack
// Busy maps for a narrow and a wide register class, with a save/restore stack
// held in a single-port synchronous memory.
// Result: the response is registered on the request transfer; a pop from a
//   non-empty stack first enters ST_POP, where the stack memory read returns.
// Throughput: 1 request per cycle while responses are taken; no new request
//   is taken while a pop that hit the stack memory is in ST_POP.
// Reset: maps cleared, stack empty; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module register_allocator_with_context_stack
	import rac_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	rac_req_if.sink       req,
	rac_rsp_if.source     rsp
);

	state_t           st_q, st_d;
	narrow_map_t      narrow_q, narrow_d;
	wide_map_t        wide_q, wide_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             rsp_valid_q;
	logic [IDX_W-1:0] granted_q, grant_d;
	err_t             err_q, err_d;
	logic             load_rsp;

	// stack memory
	logic [MAP_W-1:0]  stack_mem [STACK_DEPTH];
	logic [MAP_W-1:0]  rd_data_s1;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CNT_W-1:0]  cnt_dec;

	// decode
	logic             accept;
	op_t              op;
	logic             in_range;
	logic             hit;
	narrow_map_t      n_onehot;
	wide_map_t        w_onehot;
	logic             n_free, w_free;
	logic [IDX_W-1:0] n_first, w_first;

	assign req.ready = (st_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign op        = op_t'(req.operation);

	assign n_onehot = narrow_map_t'(1) << req.reg_index;
	assign w_onehot = wide_map_t'(1) << req.reg_index;
	assign in_range = req.wide_class ? (32'(req.reg_index) < 32'(WIDE_REGS))
	                                 : (32'(req.reg_index) < 32'(NARROW_REGS));
	assign hit      = req.wide_class ? |(wide_q & w_onehot) : |(narrow_q & n_onehot);

	// lowest free register of each class
	always_comb begin
		n_free  = 1'b0;
		n_first = '0;
		for (int i = NARROW_REGS - 1; i >= 0; i--) begin
			if (!narrow_q[i]) begin
				n_free  = 1'b1;
				n_first = IDX_W'(i);
			end
		end
		w_free  = 1'b0;
		w_first = '0;
		for (int i = WIDE_REGS - 1; i >= 0; i--) begin
			if (!wide_q[i]) begin
				w_free  = 1'b1;
				w_first = IDX_W'(i);
			end
		end
	end

	assign cnt_dec = count_q - CNT_W'(1);
	assign waddr   = count_q[ADDR_W-1:0];
	assign raddr   = cnt_dec[ADDR_W-1:0];

	always_comb begin
		st_d     = st_q;
		narrow_d = narrow_q;
		wide_d   = wide_q;
		count_d  = count_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		load_rsp = 1'b0;
		grant_d  = '0;
		err_d    = ERR_OK;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					load_rsp = 1'b1;
					case (op)
						OP_CLAIM: begin
							if (!in_range) begin
								err_d = ERR_RANGE;
							end else if (hit) begin
								err_d = ERR_BUSY;
							end else begin
								grant_d = req.reg_index;
								if (req.wide_class) wide_d = wide_q | w_onehot;
								else                narrow_d = narrow_q | n_onehot;
							end
						end
						OP_ALLOC: begin
							if (req.wide_class) begin
								if (w_free) begin
									grant_d = w_first;
									wide_d  = wide_q | (wide_map_t'(1) << w_first);
								end else begin
									err_d = ERR_NONE_FREE;
								end
							end else begin
								if (n_free) begin
									grant_d  = n_first;
									narrow_d = narrow_q | (narrow_map_t'(1) << n_first);
								end else begin
									err_d = ERR_NONE_FREE;
								end
							end
						end
						OP_RELEASE: begin
							if (!in_range) begin
								err_d = ERR_RANGE;
							end else if (req.wide_class) begin
								wide_d = wide_q & ~w_onehot;
							end else begin
								narrow_d = narrow_q & ~n_onehot;
							end
						end
						OP_RELEASE_ALL: begin
							narrow_d = '0;
							wide_d   = '0;
						end
						OP_PUSH: begin
							if (count_q >= CNT_W'(STACK_DEPTH)) begin
								err_d = ERR_STACK_FULL;
							end else begin
								mem_we   = 1'b1;
								count_d  = count_q + CNT_W'(1);
								narrow_d = '0;
								wide_d   = '0;
							end
						end
						OP_POP: begin
							// empty stack: plain ok response, nothing changes
							if (count_q != '0) begin
								mem_re   = 1'b1;
								count_d  = cnt_dec;
								load_rsp = 1'b0;
								st_d     = ST_POP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_POP: begin
				// read data of the top entry arrives this cycle
				narrow_d = rd_data_s1[MAP_W-1:WIDE_REGS];
				wide_d   = rd_data_s1[WIDE_REGS-1:0];
				load_rsp = 1'b1;
				st_d     = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// Writes and reads never overlap on one entry: a pop read is issued only
	// in a later transfer than the push that wrote it.
	always_ff @(posedge clk) begin
		if (mem_we) stack_mem[waddr] <= {narrow_q, wide_q};
		if (mem_re) rd_data_s1 <= stack_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			narrow_q    <= '0;
			wide_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			narrow_q <= narrow_d;
			wide_q   <= wide_d;
			count_q  <= count_d;
			if (load_rsp)       rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			granted_q <= grant_d;
			err_q     <= err_d;
		end
	end

	// maps only change on a new transfer or in ST_POP, so they hold while the response waits
	assign rsp.valid         = rsp_valid_q;
	assign rsp.granted_index = granted_q;
	assign rsp.error_code    = err_q;
	assign rsp.narrow_map    = narrow_q;
	assign rsp.wide_map      = wide_q;

endmodule

### tb/tb_register_allocator_with_context_stack.sv
// ----------------------------------------------------------------------------
// tb_register_allocator_with_context_stack
// Self-checking bench. A queue of requests feeds a driver that transfers them
// with random idle bursts. Each transfer updates a local copy of the busy maps
// and the context stack, and the predicted response is queued. A monitor
// takes responses under random stalls and checks every field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_register_allocator_with_context_stack;
	import rac_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQS = 800;
	localparam int CALM_TAIL   = 120;

	localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic             wide_class;
		logic [IDX_W-1:0] reg_index;
	} alloc_req_t;

	typedef struct {
		logic [IDX_W-1:0] granted_index;
		err_t             error_code;
		narrow_map_t      narrow_map;
		wide_map_t        wide_map;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;

	rac_req_if req_ch ();
	rac_rsp_if rsp_ch ();

	register_allocator_with_context_stack u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the allocator state
	narrow_map_t busy_n;
	wide_map_t   busy_w;
	narrow_map_t ctx_n [STACK_DEPTH];
	wide_map_t   ctx_w [STACK_DEPTH];
	int          ctx_depth;

	alloc_req_t pending_reqs[$];
	alloc_rsp_t expected_rsps[$];

	int   mismatches;
	int   rsp_count;
	int   cycles;
	int   send_gap;
	int   stall_left;
	logic calm;
	logic nxt_valid;

	alloc_req_t next_req;
	alloc_req_t taken_req;
	alloc_rsp_t predicted;
	alloc_rsp_t want;

	task automatic predict_response(input alloc_req_t rq, output alloc_rsp_t rs);
		logic [31:0] map;
		int          size;
		int          i;
		bit          found;
		bit          touched;
		rs.granted_index = '0;
		rs.error_code    = ERR_OK;
		size    = rq.wide_class ? WIDE_REGS : NARROW_REGS;
		map     = rq.wide_class ? 32'(busy_w) : 32'(busy_n);
		found   = 1'b0;
		touched = 1'b0;
		case (rq.operation)
			OP_CLAIM: begin
				if (rq.reg_index >= size) begin
					rs.error_code = ERR_RANGE;
				end else if (map[rq.reg_index]) begin
					rs.error_code = ERR_BUSY;
				end else begin
					map[rq.reg_index] = 1'b1;
					rs.granted_index  = rq.reg_index;
					touched           = 1'b1;
				end
			end
			OP_ALLOC: begin
				rs.error_code = ERR_NONE_FREE;
				for (i = 0; i < size; i++) begin
					if (!found && !map[i]) begin
						found            = 1'b1;
						map[i]           = 1'b1;
						rs.granted_index = IDX_W'(i);
						rs.error_code    = ERR_OK;
						touched          = 1'b1;
					end
				end
			end
			OP_RELEASE: begin
				if (rq.reg_index >= size) begin
					rs.error_code = ERR_RANGE;
				end else begin
					map[rq.reg_index] = 1'b0;
					touched           = 1'b1;
				end
			end
			OP_RELEASE_ALL: begin
				busy_n = '0;
				busy_w = '0;
			end
			OP_PUSH: begin
				if (ctx_depth >= STACK_DEPTH) begin
					rs.error_code = ERR_STACK_FULL;
				end else begin
					ctx_n[ctx_depth] = busy_n;
					ctx_w[ctx_depth] = busy_w;
					ctx_depth++;
					busy_n = '0;
					busy_w = '0;
				end
			end
			OP_POP: begin
				// empty stack: no change, no error
				if (ctx_depth > 0) begin
					ctx_depth--;
					busy_n = ctx_n[ctx_depth];
					busy_w = ctx_w[ctx_depth];
				end
			end
			default: begin
			end
		endcase
		if (touched) begin
			if (rq.wide_class)
				busy_w = map[WIDE_REGS-1:0];
			else
				busy_n = map[NARROW_REGS-1:0];
		end
		rs.narrow_map = busy_n;
		rs.wide_map   = busy_w;
	endtask

	task automatic add_req(input logic [OP_W-1:0] op, input logic wide,
		input logic [IDX_W-1:0] idx);
		alloc_req_t rq;
		rq.operation  = op;
		rq.wide_class = wide;
		rq.reg_index  = idx;
		pending_reqs.push_back(rq);
	endtask

	task automatic add_random_req();
		int          pick;
		logic        wide;
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		pick = $urandom_range(0, 99);
		wide = 1'($urandom_range(0, 1));
		if (pick < 28)
			op = OP_CLAIM;
		else if (pick < 54)
			op = OP_ALLOC;
		else if (pick < 74)
			op = OP_RELEASE;
		else if (pick < 78)
			op = OP_RELEASE_ALL;
		else if (pick < 87)
			op = OP_PUSH;
		else if (pick < 96)
			op = OP_POP;
		else
			op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
		// mostly in range, sometimes any 3-bit index
		if ($urandom_range(0, 4) != 0)
			idx = IDX_W'($urandom_range(0, (wide ? WIDE_REGS : NARROW_REGS) - 1));
		else
			idx = IDX_W'($urandom_range(0, 7));
		add_req(op, wide, idx);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.operation  <= '0;
			req_ch.wide_class <= 1'b0;
			req_ch.reg_index  <= '0;
			calm              <= 1'b0;
			send_gap          = 0;
		end else begin
			nxt_valid = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				taken_req.operation  = req_ch.operation;
				taken_req.wide_class = req_ch.wide_class;
				taken_req.reg_index  = req_ch.reg_index;
				predict_response(taken_req, predicted);
				expected_rsps.push_back(predicted);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					nxt_valid = 1'b0;
				end else if (pending_reqs.size() == 0) begin
					nxt_valid = 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					send_gap  = $urandom_range(1, 9) - 1;
					nxt_valid = 1'b0;
				end else begin
					next_req = pending_reqs.pop_front();
					nxt_valid = 1'b1;
					req_ch.operation  <= next_req.operation;
					req_ch.wide_class <= next_req.wide_class;
					req_ch.reg_index  <= next_req.reg_index;
				end
			end
			req_ch.valid <= nxt_valid;
			calm         <= (pending_reqs.size() < CALM_TAIL);
		end
	end

	// Response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left   = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_count++;
				if (expected_rsps.size() == 0) begin
					$display("%0t: response %0d with none expected (error %0d)", $time,
						rsp_count, rsp_ch.error_code);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.granted_index !== want.granted_index) begin
						$display("%0t: response %0d granted_index expected %0d actual %0d",
							$time, rsp_count, want.granted_index, rsp_ch.granted_index);
						mismatches++;
					end
					if (rsp_ch.error_code !== want.error_code) begin
						$display("%0t: response %0d error_code expected %0d actual %0d",
							$time, rsp_count, want.error_code, rsp_ch.error_code);
						mismatches++;
					end
					if (rsp_ch.narrow_map !== want.narrow_map) begin
						$display("%0t: response %0d narrow_map expected %b actual %b",
							$time, rsp_count, want.narrow_map, rsp_ch.narrow_map);
						mismatches++;
					end
					if (rsp_ch.wide_map !== want.wide_map) begin
						$display("%0t: response %0d wide_map expected %b actual %b",
							$time, rsp_count, want.wide_map, rsp_ch.wide_map);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses still expected", $time,
				expected_rsps.size());
			$display("** register_allocator_with_context_stack: FAILED **");
			$finish;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = '0;
		req_ch.wide_class = 1'b0;
		req_ch.reg_index  = '0;
		rsp_ch.ready      = 1'b0;
		busy_n            = '0;
		busy_w            = '0;
		ctx_depth         = 0;
		mismatches        = 0;
		rsp_count         = 0;
		cycles            = 0;

		// directed: edges of both classes, every error but a full stack, empty-stack pop, spare codes
		add_req(OP_CLAIM, 1'b0, 3'd0);
		add_req(OP_CLAIM, 1'b0, 3'd5);
		add_req(OP_CLAIM, 1'b0, 3'd5);
		add_req(OP_CLAIM, 1'b0, 3'd6);
		add_req(OP_CLAIM, 1'b1, 3'd3);
		add_req(OP_CLAIM, 1'b1, 3'd7);
		repeat (5) add_req(OP_ALLOC, 1'b0, 3'd0);
		repeat (4) add_req(OP_ALLOC, 1'b1, 3'd7);
		add_req(OP_RELEASE, 1'b0, 3'd7);
		add_req(OP_RELEASE, 1'b1, 3'd4);
		add_req(OP_RELEASE, 1'b0, 3'd2);
		add_req(OP_RELEASE, 1'b0, 3'd2);
		add_req(OP_PUSH, 1'b0, 3'd0);
		add_req(OP_POP, 1'b1, 3'd0);
		add_req(OP_POP, 1'b0, 3'd0);
		add_req(OP_RELEASE_ALL, 1'b1, 3'd0);
		add_req(OP_UNUSED_A, 1'b1, 3'd7);
		add_req(OP_UNUSED_B, 1'b0, 3'd0);

		// random: plain runs, plus stack fill and drain sequences with traffic between
		while (pending_reqs.size() < RANDOM_REQS + 25) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(16, 20)) begin
						repeat ($urandom_range(0, 3)) add_random_req();
						add_req(OP_PUSH, 1'($urandom_range(0, 1)),
							IDX_W'($urandom_range(0, 7)));
					end
				end
				1: begin
					repeat ($urandom_range(16, 20)) begin
						repeat ($urandom_range(0, 2)) add_random_req();
						add_req(OP_POP, 1'($urandom_range(0, 1)),
							IDX_W'($urandom_range(0, 7)));
					end
				end
				default: begin
					repeat ($urandom_range(4, 24)) add_random_req();
				end
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		if (mismatches == 0)
			$display("** register_allocator_with_context_stack: PASSED **");
		else
			$display("** register_allocator_with_context_stack: FAILED **");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/rac_pkg.sv
hw/rtl/rac_req_if.sv
hw/rtl/rac_rsp_if.sv
hw/rtl/register_allocator_with_context_stack.sv
tb/tb_register_allocator_with_context_stack.sv
